### rtl/euler_totient_top_macros.svh
// Assertion macros for the euler totient checker file, etot_check.sv.
// Depends on nothing; each file that asserts includes it once.
`ifndef EULER_TOTIENT_TOP_MACROS_SVH
`define EULER_TOTIENT_TOP_MACROS_SVH

// check that cons holds in the same cycle as ante
`define ETOT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// check that cons holds in the cycle after ante
`define ETOT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/etot_pkg.sv
// Package for the euler totient block: default width and the controller state type.
// Depends on nothing.
package etot_pkg;

   localparam int VALUE_WIDTH_DEF = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_STRIP,
      ST_REDUCE,
      ST_LAST,
      ST_EMIT
   } etot_state_type;

endpackage

### rtl/etot_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, quotient and remainder.
// Depends on etot_pkg.
module etot_div import etot_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [VALUE_WIDTH-1:0] divisor,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] quotient,
   output logic [VALUE_WIDTH-1:0] remainder
);

   localparam int CW = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;
   logic                   fits;

   always_comb begin
      trial = {rem_ff, quo_ff[VALUE_WIDTH-1]};
      diff  = trial - {1'b0, dsr_ff};
      fits  = ~diff[VALUE_WIDTH];
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(VALUE_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
         quo_in = {quo_ff[VALUE_WIDTH-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### rtl/euler_totient_top.sv
// Euler totient engine: trial-division controller around a bit-serial divider.
// Depends on etot_pkg and etot_div.
//
// Usage:
//   req_valid/req_ready/req_value take one unsigned word; rsp_valid/rsp_ready/
//   rsp_totient return one word, phi(value), for each word taken. Value zero
//   returns zero, value one returns one.
//   One word is worked at a time. req_ready is high whenever the engine is
//   idle, even while the previous result still waits in the output register.
//   Every trial division, strip division and reduction runs through the one
//   shared divider. The run time of a word grows with the count of trial
//   divisors plus prime factors counted with multiplicity plus distinct
//   prime factors; zero needs no division, and a large prime is tried
//   against every divisor up to its square root.
//   Reset is synchronous and clears the controller, divider and output valid.
//   If the receiver stalls, the result holds in the output register and a
//   finished next result waits in the controller until the register frees.
module euler_totient_top import etot_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VALUE_WIDTH-1:0] rsp_totient
);

   etot_state_type state_ff, state_in;

   logic [VALUE_WIDTH-1:0] rest_ff, rest_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0] dvr_ff, dvr_in;
   logic                   issue_ff, issue_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_totient_ff, rsp_totient_in;

   logic                   req_take;
   logic                   emit_take;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic [VALUE_WIDTH-1:0] div_divisor;
   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_quo;
   logic [VALUE_WIDTH-1:0] div_rem;
   logic                   rem_zero;
   logic                   past_root;
   logic                   next_is_div;

   etot_div #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (issue_ff),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign rem_zero  = (div_rem == '0);
   assign past_root = (dvr_ff > div_quo);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_value == '0) ? ST_EMIT : ST_TEST;
            end
         end
         ST_TEST: begin
            if (div_done) begin
               if (past_root) begin
                  state_in = (rest_ff > VALUE_WIDTH'(1)) ? ST_LAST : ST_EMIT;
               end else if (rem_zero) begin
                  state_in = ST_STRIP;
               end
            end
         end
         ST_STRIP: begin
            if (div_done && !rem_zero) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (div_done) begin
               state_in = ST_TEST;
            end
         end
         ST_LAST: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the controller
   always_comb begin
      req_ready    = 1'b0;
      emit_take    = 1'b0;
      div_dividend = rest_ff;
      div_divisor  = dvr_ff;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_TEST:   div_dividend = rest_ff;
         ST_STRIP:  div_dividend = rest_ff;
         ST_REDUCE: div_dividend = acc_ff;
         ST_LAST: begin
            div_dividend = acc_ff;
            div_divisor  = rest_ff;
         end
         ST_EMIT:   emit_take = !rsp_valid_ff || rsp_ready;
         default:   req_ready = 1'b0;
      endcase
   end

   assign req_take    = req_valid && req_ready;
   assign next_is_div = (state_in == ST_TEST) || (state_in == ST_STRIP) ||
                        (state_in == ST_REDUCE) || (state_in == ST_LAST);
   assign issue_in    = next_is_div && ((state_in != state_ff) || div_done);

   // datapath
   always_comb begin
      rest_in = rest_ff;
      acc_in  = acc_ff;
      dvr_in  = dvr_ff;
      if (req_take) begin
         rest_in = req_value;
         acc_in  = req_value;
         dvr_in  = VALUE_WIDTH'(2);
      end else if (div_done) begin
         case (state_ff)
            ST_TEST: begin
               if (!past_root) begin
                  if (rem_zero) begin
                     rest_in = div_quo;
                  end else begin
                     dvr_in = dvr_ff + VALUE_WIDTH'(1);
                  end
               end
            end
            ST_STRIP: begin
               if (rem_zero) begin
                  rest_in = div_quo;
               end
            end
            ST_REDUCE: begin
               acc_in = acc_ff - div_quo;
               dvr_in = dvr_ff + VALUE_WIDTH'(1);
            end
            ST_LAST:  acc_in = acc_ff - div_quo;
            default:  acc_in = acc_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_totient_in = rsp_totient_ff;
      if (emit_take) begin
         rsp_valid_in   = 1'b1;
         rsp_totient_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff        <= rest_in;
      acc_ff         <= acc_in;
      dvr_ff         <= dvr_in;
      rsp_totient_ff <= rsp_totient_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_totient = rsp_totient_ff;

endmodule

### rtl/etot_check.sv
// Port-level checker for euler_totient_top, bound to every instance.
// Depends on etot_pkg and euler_totient_top_macros.svh.
`include "euler_totient_top_macros.svh"

module etot_check import etot_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [VALUE_WIDTH-1:0] rsp_totient
);

   `ETOT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp_valid dropped while stalled")

   `ETOT_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_totient), "rsp_totient changed while stalled")

   `ETOT_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready, "req_ready high right after a word was taken")

endmodule

bind euler_totient_top etot_check #(
   .VALUE_WIDTH(VALUE_WIDTH)
) u_etot_check (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_totient (rsp_totient)
);

### sim/euler_totient_top_test.sv
// Testbench for euler_totient_top: sends directed and random words and checks each
// returned totient against a trial-division predictor computed in the bench.
// Depends on etot_pkg and the euler_totient_top RTL.
module euler_totient_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_WIDTH = etot_pkg::VALUE_WIDTH_DEF;
   localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_WIDTH) - 1;
   localparam int DRAIN_CYCLES = 200;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [VALUE_WIDTH-1:0] req_value = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [VALUE_WIDTH-1:0] rsp_totient;

   logic [VALUE_WIDTH-1:0] due_value[$];
   logic [VALUE_WIDTH-1:0] due_totient[$];
   int                     errors = 0;
   int                     checked = 0;
   int                     sent = 0;
   int                     burst_left = 0;
   int                     stall_left = 0;
   int                     stall_mode = 0;

   euler_totient_top #(.VALUE_WIDTH(VALUE_WIDTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_totient(rsp_totient)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [VALUE_WIDTH-1:0] phi_of(input logic [VALUE_WIDTH-1:0] value);
      longint unsigned rest;
      longint unsigned acc;
      longint unsigned d;
      if (value == '0) return '0;
      rest = value;
      acc = value;
      for (d = 2; d <= rest / d; d++) begin
         if (rest % d == 0) begin
            while (rest % d == 0) rest = rest / d;
            acc = acc - acc / d;
         end
      end
      if (rest > 1) acc = acc - acc / rest;
      return acc[VALUE_WIDTH-1:0];
   endfunction

   // keep the largest prime factor below 2^16 and the rest below 256 so each word stays quick
   function automatic logic [VALUE_WIDTH-1:0] smooth_value();
      longint unsigned v;
      longint unsigned f;
      int misses;
      v = ($urandom_range(1, 0) == 1) ? longint'($urandom_range(65535, 2)) : 1;
      misses = 0;
      while (misses < 4) begin
         f = $urandom_range(255, 2);
         if (v * f > VALUE_MAX) misses++;
         else v = v * f;
      end
      return v[VALUE_WIDTH-1:0];
   endfunction

   task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(40, 1);
         burst_left = $urandom_range(8, 1);
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      due_value.push_back(value);
      due_totient.push_back(phi_of(value));
      sent++;
   endtask

   task automatic test_zero_and_one();
      send_value('0);
      send_value(1);
      send_value(2);
      send_value(3);
      send_value(4);
   endtask

   task automatic test_prime_powers();
      send_value(49);
      send_value(243);
      send_value(65536);
      send_value(65537);
      send_value(32'h8000_0000);
      send_value(32'hFFFE_0001);
   endtask

   task automatic test_composites();
      send_value(6);
      send_value(30);
      send_value(210);
      send_value(9699690);
      send_value(223092870);
      send_value(32'hFFFF_0000);
      send_value(32'h5555_5555);
      send_value(32'hAAAA_AAAA);
      send_value(32'hFFFF_FFFF);
   endtask

   task automatic test_large_prime();
      send_value(16777213);
   endtask

   task automatic test_random_small(input int count);
      repeat (count) send_value($urandom_range(65535, 0));
   endtask

   task automatic test_random_smooth(input int count);
      repeat (count) send_value(smooth_value());
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_totient.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // receiver: switch among always ready, a toggling pattern and heavy stalls
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(2, 0);
         stall_left = $urandom_range(200, 20);
      end else begin
         stall_left = stall_left - 1;
      end
      case (stall_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= stall_left[2] | stall_left[0];
         end
         default: begin
            rsp_ready <= ($urandom_range(3, 0) == 0);
         end
      endcase
   end

   always @(posedge clock) begin : check_totient
      logic [VALUE_WIDTH-1:0] want_value;
      logic [VALUE_WIDTH-1:0] want_totient;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_totient.size() == 0) begin
            $display("%0t: unexpected word, got totient %0d", $time, rsp_totient);
            errors++;
         end else begin
            want_value = due_value.pop_front();
            want_totient = due_totient.pop_front();
            if (rsp_totient !== want_totient) begin
               $display("%0t: totient of %0d expected %0d, got %0d",
                        $time, want_value, want_totient, rsp_totient);
               errors++;
            end
            checked++;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_zero_and_one();
      test_prime_powers();
      test_composites();
      test_large_prime();
      test_random_small(35);
      test_random_smooth(65);
      wait_drain();
      $display("Checked %0d totients over %0d words: zero, one, prime powers, smooth", checked, sent);
      $display("composites, a 24-bit prime and random small and smooth values.");
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d words still due", due_totient.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/etot_pkg.sv
rtl/etot_div.sv
rtl/euler_totient_top.sv
rtl/etot_check.sv
sim/euler_totient_top_test.sv
